/* src/text_lcd_row_buffer_scroll_macros.svh */
// Assertion macros used by the checker file of the text row buffer.
`ifndef TEXT_LCD_ROW_BUFFER_SCROLL_MACROS_SVH
`define TEXT_LCD_ROW_BUFFER_SCROLL_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LCDRB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LCDRB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/lcdrb_pkg.sv */
// Types and constants shared by the text row buffer modules.
package lcdrb_pkg;

   localparam int ROW_COUNT = 2;
   localparam int QUEUE_DEPTH = 2;
   localparam logic [7:0] SPACE_CHAR = 8'h20;

   typedef enum logic [1:0] {
      OP_WRITE      = 2'd0,
      OP_CLEAR      = 2'd1,
      OP_HOME       = 2'd2,
      OP_SET_CURSOR = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      MODE_NONE  = 2'd0,
      MODE_LEFT  = 2'd1,
      MODE_RIGHT = 2'd2
   } scroll_mode_type;

   typedef enum logic [2:0] {
      CMD_WRITE      = 3'd0,
      CMD_RENDER     = 3'd1,
      CMD_CLEAR      = 3'd2,
      CMD_HOME       = 3'd3,
      CMD_SET_CURSOR = 3'd4
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   char_value;
      logic [7:0]   column;
      logic         row_select;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic {
      BK_IDLE   = 1'b0,
      BK_RENDER = 1'b1
   } back_state_type;

endpackage

/* src/text_lcd_row_buffer_scroll.sv */
// Top level of the two-row character display text buffer with scrolling window.
//
// Requests: raise start with req_opcode, req_char_value, req_column and
// req_row_select; the request is taken at a rising edge where busy is low.
// Opcodes: write byte, clear, home, set cursor. Writing byte zero renders
// both rows through the window before the zero is stored.
// A render puts out 2 x WINDOW_CHARS characters on rsp_out_row,
// rsp_out_column and rsp_out_char, one per cycle, each marked by
// rsp_strobe for a single cycle; rsp_last flags the final one. The receiver
// cannot stall, so results are never held back.
// A request passes from the intake register through the command queue
// to the execution side; render output leaves through the state and
// output registers. A render holds the execution side while it walks the
// text memory one character per cycle; other requests are carried out
// as they are popped. A two-entry queue lets new requests be taken during
// a render; busy rises once it and the intake register are full.
// csr_we with csr_wdata writes the scroll mode; write it only while idle.
// Reset (synchronous, high) empties the store, cursors, offset and mode.
module text_lcd_row_buffer_scroll
   import lcdrb_pkg::*;
#(
   parameter int ROW_CHARS    = 40,
   parameter int WINDOW_CHARS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_opcode,
   input  logic [7:0] req_char_value,
   input  logic [7:0] req_column,
   input  logic       req_row_select,
   input  logic       csr_we,
   input  logic [1:0] csr_wdata,
   output logic       rsp_strobe,
   output logic       rsp_out_row,
   output logic [3:0] rsp_out_column,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last
);

   logic [1:0]   mode_ff, mode_in;
   logic         push, pop;
   cmd_type      push_cmd, head_cmd;
   q_status_type q_status;

   assign mode_in = csr_we ? csr_wdata : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NONE;
      end else begin
         mode_ff <= mode_in;
      end
   end

   lcdrb_front u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_char_value (req_char_value),
      .req_column     (req_column),
      .req_row_select (req_row_select),
      .q_status       (q_status),
      .push           (push),
      .push_cmd       (push_cmd)
   );

   lcdrb_cmdq u_cmdq (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_status (q_status)
   );

   lcdrb_back #(
      .ROW_CHARS    (ROW_CHARS),
      .WINDOW_CHARS (WINDOW_CHARS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .scroll_mode    (mode_ff),
      .q_status       (q_status),
      .head_cmd       (head_cmd),
      .pop            (pop),
      .rsp_strobe     (rsp_strobe),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_column (rsp_out_column),
      .rsp_out_char   (rsp_out_char),
      .rsp_last       (rsp_last)
   );

endmodule

/* src/lcdrb_front.sv */
// Request intake: accepts a request, classifies it and hands it to the command queue.
module lcdrb_front
   import lcdrb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [1:0]   req_opcode,
   input  logic [7:0]   req_char_value,
   input  logic [7:0]   req_column,
   input  logic         req_row_select,
   input  q_status_type q_status,
   output logic         push,
   output cmd_type      push_cmd
);

   logic    vld_ff, vld_in;
   cmd_type cmd_ff, cmd_in;
   cmd_type decoded;
   logic    accept;

   always_comb begin
      decoded.char_value = req_char_value;
      decoded.column     = req_column;
      decoded.row_select = req_row_select;
      case (opcode_type'(req_opcode))
         OP_WRITE: begin
            decoded.kind = (req_char_value == 8'd0) ? CMD_RENDER : CMD_WRITE;
         end
         OP_CLEAR:      decoded.kind = CMD_CLEAR;
         OP_HOME:       decoded.kind = CMD_HOME;
         OP_SET_CURSOR: decoded.kind = CMD_SET_CURSOR;
         default:       decoded.kind = CMD_SET_CURSOR;
      endcase
   end

   assign busy     = vld_ff & q_status.full;
   assign accept   = start & ~busy;
   assign push     = vld_ff & ~q_status.full;
   assign push_cmd = cmd_ff;

   always_comb begin
      vld_in = accept | (vld_ff & ~push);
      cmd_in = accept ? decoded : cmd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

endmodule

/* src/lcdrb_cmdq.sv */
// Short command queue between the intake and the execution side.
module lcdrb_cmdq
   import lcdrb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  cmd_type      push_cmd,
   input  logic         pop,
   output cmd_type      head_cmd,
   output q_status_type q_status
);

   localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [QAW-1:0] LAST_SLOT = QAW'(QUEUE_DEPTH - 1);
   localparam logic [QCW-1:0] FULL_CNT  = QCW'(QUEUE_DEPTH);

   cmd_type        slot_ff [QUEUE_DEPTH];
   logic [QAW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [QCW-1:0] cnt_ff, cnt_in;
   logic           do_push, do_pop;

   assign q_status.full  = (cnt_ff == FULL_CNT);
   assign q_status.empty = (cnt_ff == '0);
   assign head_cmd       = slot_ff[rp_ff];

   always_comb begin
      do_push = push & ~q_status.full;
      do_pop  = pop & ~q_status.empty;
      wp_in   = wp_ff;
      rp_in   = rp_ff;
      cnt_in  = cnt_ff;
      if (do_push) begin
         wp_in = (wp_ff == LAST_SLOT) ? '0 : wp_ff + QAW'(1);
      end
      if (do_pop) begin
         rp_in = (rp_ff == LAST_SLOT) ? '0 : rp_ff + QAW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + QCW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - QCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wp_ff] <= push_cmd;
      end
   end

endmodule

/* src/lcdrb_back.sv */
// Execution side: text store, cursors, scroll offset and the render walk.
module lcdrb_back
   import lcdrb_pkg::*;
#(
   parameter int ROW_CHARS    = 40,
   parameter int WINDOW_CHARS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [1:0]   scroll_mode,
   input  q_status_type q_status,
   input  cmd_type      head_cmd,
   output logic         pop,
   output logic         rsp_strobe,
   output logic         rsp_out_row,
   output logic [3:0]   rsp_out_column,
   output logic [7:0]   rsp_out_char,
   output logic         rsp_last
);

   localparam int PW = $clog2(ROW_CHARS);
   localparam int AW = $clog2(ROW_COUNT * ROW_CHARS);
   localparam int JW = $clog2(WINDOW_CHARS);
   localparam int CW = (JW > 4) ? JW : 4;
   localparam int OW = $clog2(ROW_CHARS + 1) + 1;
   localparam int SW = OW + 1;
   localparam int NZW = ROW_COUNT * ROW_CHARS;
   localparam logic [PW-1:0] LAST_POS = PW'(ROW_CHARS - 1);
   localparam logic [JW-1:0] LAST_J   = JW'(WINDOW_CHARS - 1);
   localparam logic [7:0]    ROW_LEN8 = 8'(ROW_CHARS);
   localparam logic [7:0]    ROW_END8 = 8'(ROW_CHARS - 1);
   localparam logic [AW-1:0] ROW1_BASE = AW'(ROW_CHARS);
   localparam logic signed [OW-1:0] OFF_MAX = OW'(ROW_CHARS);
   localparam logic signed [OW-1:0] OFF_MIN = -OFF_MAX;
   localparam logic signed [SW-1:0] ROW_S   = SW'(ROW_CHARS);

   back_state_type        state_ff, state_in;
   logic [7:0]            cur_ff [ROW_COUNT];
   logic [7:0]            cur_in [ROW_COUNT];
   logic                  act_ff, act_in;
   logic signed [OW-1:0]  off_ff, off_in, off_nx;
   logic [NZW-1:0]        nz_ff, nz_in;
   logic [PW-1:0]         pos_ff, pos_in, base_ff, base_in, base_nx;
   logic                  row_ff, row_in;
   logic [JW-1:0]         j_ff, j_in;
   logic                  ev_ff, ev_in;
   logic                  erow_ff, erow_in;
   logic [JW-1:0]         ecol_ff, ecol_in;
   logic                  elast_ff, elast_in;
   logic                  evis_ff, evis_in;
   logic [7:0]            rd_ff;
   logic [7:0]            mem [NZW];
   logic                  do_write, mem_we;
   logic [7:0]            wchar, wpos;
   logic [AW-1:0]         widx, ra;
   logic signed [SW-1:0]  st, s1, s2, s3;
   logic [ROW_CHARS-1:0]  mask, nz_row;
   logic                  vis;
   logic [CW-1:0]         ecol_x;

   // Window start and offset update for the next render.
   always_comb begin
      case (scroll_mode)
         MODE_LEFT: begin
            st     = SW'(off_ff);
            off_nx = off_ff + OW'(1);
            if (off_nx > OFF_MAX) begin
               off_nx = '0;
            end
         end
         MODE_RIGHT: begin
            st     = ROW_S + SW'(off_ff);
            off_nx = off_ff - OW'(1);
            if (off_nx < OFF_MIN) begin
               off_nx = '0;
            end
         end
         default: begin
            st     = '0;
            off_nx = '0;
         end
      endcase
      // fold the start into one row period
      s1 = (st < 0) ? st + ROW_S : st;
      s2 = (s1 >= ROW_S) ? s1 - ROW_S : s1;
      s3 = (s2 >= ROW_S) ? s2 - ROW_S : s2;
      base_nx = s3[PW-1:0];
   end

   // A position shows text only if every byte up to it is nonzero.
   always_comb begin
      for (int i = 0; i < ROW_CHARS; i++) begin
         mask[i] = (PW'(i) <= pos_ff);
      end
      nz_row = row_ff ? nz_ff[NZW-1:ROW_CHARS] : nz_ff[ROW_CHARS-1:0];
      vis    = &(nz_row | ~mask);
      ra     = row_ff ? ROW1_BASE + AW'(pos_ff) : AW'(pos_ff);
   end

   always_comb begin
      state_in = state_ff;
      for (int r = 0; r < ROW_COUNT; r++) begin
         cur_in[r] = cur_ff[r];
      end
      act_in   = act_ff;
      off_in   = off_ff;
      nz_in    = nz_ff;
      pos_in   = pos_ff;
      base_in  = base_ff;
      row_in   = row_ff;
      j_in     = j_ff;
      pop      = 1'b0;
      do_write = 1'b0;
      wchar    = head_cmd.char_value;
      ev_in    = 1'b0;
      erow_in  = row_ff;
      ecol_in  = j_ff;
      elast_in = 1'b0;
      evis_in  = vis;
      mem_we   = 1'b0;

      case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) begin
               pop = 1'b1;
               case (head_cmd.kind)
                  CMD_WRITE: do_write = 1'b1;
                  CMD_RENDER: begin
                     state_in = BK_RENDER;
                     off_in   = off_nx;
                     base_in  = base_nx;
                     pos_in   = base_nx;
                     row_in   = 1'b0;
                     j_in     = '0;
                  end
                  CMD_CLEAR: begin
                     for (int r = 0; r < ROW_COUNT; r++) begin
                        cur_in[r] = '0;
                     end
                     act_in = 1'b0;
                     off_in = '0;
                     nz_in  = '0;
                  end
                  CMD_HOME: begin
                     for (int r = 0; r < ROW_COUNT; r++) begin
                        cur_in[r] = '0;
                     end
                     act_in = 1'b0;
                  end
                  CMD_SET_CURSOR: begin
                     cur_in[head_cmd.row_select] = head_cmd.column;
                     act_in = head_cmd.row_select;
                  end
                  default: ;
               endcase
            end
         end
         BK_RENDER: begin
            ev_in    = 1'b1;
            elast_in = row_ff & (j_ff == LAST_J);
            pos_in   = (pos_ff == LAST_POS) ? '0 : pos_ff + PW'(1);
            j_in     = j_ff + JW'(1);
            if (j_ff == LAST_J) begin
               j_in   = '0;
               pos_in = base_ff;
               row_in = 1'b1;
               if (row_ff) begin
                  // store the zero byte once both rows are out
                  state_in = BK_IDLE;
                  do_write = 1'b1;
                  wchar    = 8'd0;
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase

      wpos = cur_ff[act_ff];
      widx = act_ff ? ROW1_BASE + AW'(wpos[PW-1:0]) : AW'(wpos[PW-1:0]);
      if (do_write && (wpos < ROW_LEN8)) begin
         mem_we      = 1'b1;
         nz_in[widx] = (wchar != 8'd0);
         if (wpos < ROW_END8) begin
            nz_in[widx + AW'(1)] = 1'b0;
         end
         cur_in[act_ff] = wpos + 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         for (int r = 0; r < ROW_COUNT; r++) begin
            cur_ff[r] <= '0;
         end
         act_ff <= 1'b0;
         off_ff <= '0;
         nz_ff  <= '0;
         ev_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         for (int r = 0; r < ROW_COUNT; r++) begin
            cur_ff[r] <= cur_in[r];
         end
         act_ff <= act_in;
         off_ff <= off_in;
         nz_ff  <= nz_in;
         ev_ff  <= ev_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      base_ff  <= base_in;
      row_ff   <= row_in;
      j_ff     <= j_in;
      erow_ff  <= erow_in;
      ecol_ff  <= ecol_in;
      elast_ff <= elast_in;
      evis_ff  <= evis_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[widx] <= wchar;
      end
      rd_ff <= mem[ra];
   end

   assign ecol_x         = CW'(ecol_ff);
   assign rsp_strobe     = ev_ff;
   assign rsp_out_row    = erow_ff;
   assign rsp_out_column = ecol_x[3:0];
   assign rsp_out_char   = evis_ff ? rd_ff : SPACE_CHAR;
   assign rsp_last       = ev_ff & elast_ff;

endmodule

/* src/lcdrb_checker.sv */
// Port-level checks on the result stream of the text row buffer, with their bind.
`include "text_lcd_row_buffer_scroll_macros.svh"

module lcdrb_checker (
   input logic       clock,
   input logic       reset,
   input logic       busy,
   input logic       rsp_strobe,
   input logic       rsp_out_row,
   input logic       rsp_last
);

   // The final character belongs to the second row and is strobed.
   `LCDRB_ASSERT_NOW(a_last_on_row1, clock, reset, rsp_last, rsp_strobe && rsp_out_row, "last without strobe on second row")

   // A render comes out as one unbroken burst.
   `LCDRB_ASSERT_NEXT(a_burst_solid, clock, reset, rsp_strobe && !rsp_last, rsp_strobe, "render burst broken")

   // Rows do not go backwards inside a burst.
   `LCDRB_ASSERT_NEXT(a_row_order, clock, reset, rsp_strobe && !rsp_last && rsp_out_row, rsp_out_row, "row went backwards in a render")

   // Nothing is strobed and busy is low right after reset.
   `LCDRB_ASSERT_NOW(a_quiet_after_reset, clock, reset, $fell(reset), !rsp_strobe && !busy, "output active right after reset")

endmodule

bind text_lcd_row_buffer_scroll lcdrb_checker u_lcdrb_checker (
   .clock       (clock),
   .reset       (reset),
   .busy        (busy),
   .rsp_strobe  (rsp_strobe),
   .rsp_out_row (rsp_out_row),
   .rsp_last    (rsp_last)
);

/* test/text_lcd_row_buffer_scroll_test.sv */
// Self-checking testbench for the two-row text buffer with its scrolling render window.
`timescale 1ns / 1ps

module text_lcd_row_buffer_scroll_test;
   import lcdrb_pkg::*;

   localparam int ROW_CHARS = 40;
   localparam int WINDOW_CHARS = 16;
   localparam logic [1:0] MODE_UNDEFINED = 2'd3;
   localparam int SETTLE_CYCLES = 40;
   localparam int QUIET_LIMIT = 2000;

   typedef struct packed {
      opcode_type op;
      logic [7:0] char_value;
      logic [7:0] column;
      logic       row_select;
   } lcd_request_type;

   typedef struct packed {
      logic       row;
      logic [3:0] column;
      logic [7:0] glyph;
      logic       last;
   } lcd_glyph_type;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [1:0] req_opcode;
   logic [7:0] req_char_value;
   logic [7:0] req_column;
   logic       req_row_select;
   logic       csr_we;
   logic [1:0] csr_wdata;
   logic       rsp_strobe;
   logic       rsp_out_row;
   logic [3:0] rsp_out_column;
   logic [7:0] rsp_out_char;
   logic       rsp_last;

   text_lcd_row_buffer_scroll dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_char_value (req_char_value),
      .req_column     (req_column),
      .req_row_select (req_row_select),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .rsp_strobe     (rsp_strobe),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_column (rsp_out_column),
      .rsp_out_char   (rsp_out_char),
      .rsp_last       (rsp_last)
   );

   // Display state as the block should hold it.
   logic [7:0] text_mem [ROW_COUNT][ROW_CHARS];
   logic [7:0] cursor_pos [ROW_COUNT];
   logic       active_row_q;
   int         view_offset;
   logic [1:0] view_mode;

   lcd_request_type request_backlog[$];
   lcd_glyph_type   shown_glyphs[$];
   int              backlog_pushes = 0;
   int              issued_count = 0;
   int              taken_count = 0;
   int              mismatch_count = 0;
   int              quiet_cycles = 0;
   int              idle_pct = 31;
   bit              req_taken = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic flag_mismatch(input string what);
      $display("%0t mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   task automatic wipe_text();
      foreach (text_mem[r, c]) text_mem[r][c] = 8'h00;
      foreach (cursor_pos[r]) cursor_pos[r] = 8'h00;
      active_row_q = 1'b0;
   endtask

   // Cut the window out of each doubled row and queue the characters shown.
   task automatic render_window();
      int first;
      int len;
      int p;
      lcd_glyph_type g;
      if (view_mode == MODE_LEFT) begin
         first = view_offset;
         view_offset++;
         if (view_offset > ROW_CHARS) view_offset = 0;
      end else if (view_mode == MODE_RIGHT) begin
         first = ROW_CHARS + view_offset;
         view_offset--;
         if (view_offset < -ROW_CHARS) view_offset = 0;
      end else begin
         first = 0;
         view_offset = 0;
      end
      for (int r = 0; r < ROW_COUNT; r++) begin
         len = 0;
         while (len < ROW_CHARS && text_mem[r][len] != 8'h00) len++;
         for (int j = 0; j < WINDOW_CHARS; j++) begin
            p = (first + 2 * ROW_CHARS + j) % ROW_CHARS;
            g.row = r[0];
            g.column = j[3:0];
            g.glyph = (p < len) ? text_mem[r][p] : SPACE_CHAR;
            g.last = (r == ROW_COUNT - 1) && (j == WINDOW_CHARS - 1);
            shown_glyphs.push_back(g);
         end
      end
   endtask

   task automatic apply_request(input lcd_request_type q);
      logic ar;
      int pos;
      case (q.op)
         OP_WRITE: begin
            if (q.char_value == 8'h00) render_window();
            ar = active_row_q;
            pos = int'(cursor_pos[ar]);
            if (pos < ROW_CHARS) begin
               text_mem[ar][pos] = q.char_value;
               if (pos + 1 < ROW_CHARS) text_mem[ar][pos + 1] = 8'h00;
               cursor_pos[ar] = 8'(pos + 1);
            end
         end
         OP_CLEAR: begin
            wipe_text();
            view_offset = 0;
         end
         OP_HOME: begin
            foreach (cursor_pos[r]) cursor_pos[r] = 8'h00;
            active_row_q = 1'b0;
         end
         default: begin
            cursor_pos[q.row_select] = q.column;
            active_row_q = q.row_select;
         end
      endcase
   endtask

   task automatic queue_cmd(input opcode_type op, input logic [7:0] ch,
                            input logic [7:0] col, input logic row);
      lcd_request_type q;
      q.op = op;
      q.char_value = ch;
      q.column = col;
      q.row_select = row;
      request_backlog.push_back(q);
      backlog_pushes++;
   endtask

   // Hold until every request is taken and every rendered character has come out.
   task automatic wait_idle();
      do @(negedge clock);
      while (request_backlog.size() != 0 || issued_count != taken_count ||
             shown_glyphs.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_scroll_mode(input logic [1:0] mode);
      wait_idle();
      csr_we <= 1'b1;
      csr_wdata <= mode;
      @(negedge clock);
      csr_we <= 1'b0;
      view_mode = mode;
   endtask

   task automatic add_random_traffic(input int count, input bit allow_clear);
      int target;
      int pick;
      logic r;
      target = backlog_pushes + count;
      while (backlog_pushes < target) begin
         pick = $urandom_range(99);
         r = 1'($urandom_range(1));
         if (pick < 35) begin
            // short text then render
            if ($urandom_range(1))
               queue_cmd(OP_SET_CURSOR, 8'($urandom), 8'($urandom_range(ROW_CHARS - 1)), r);
            repeat ($urandom_range(8, 1))
               queue_cmd(OP_WRITE, 8'($urandom_range(255, 1)), 8'($urandom), 1'($urandom));
            queue_cmd(OP_WRITE, 8'h00, 8'($urandom), 1'($urandom));
         end else if (pick < 65) begin
            queue_cmd(OP_WRITE, 8'h00, 8'($urandom), 1'($urandom));
         end else if (pick < 73) begin
            // fill the whole row, running past its end
            queue_cmd(OP_SET_CURSOR, 8'($urandom), 8'd0, r);
            repeat ($urandom_range(ROW_CHARS + 3, ROW_CHARS))
               queue_cmd(OP_WRITE, 8'($urandom_range(255, 1)), 8'($urandom), 1'($urandom));
            queue_cmd(OP_WRITE, 8'h00, 8'($urandom), 1'($urandom));
         end else if (pick < 80) begin
            queue_cmd(OP_HOME, 8'($urandom), 8'($urandom), 1'($urandom));
         end else if (pick < 82 && allow_clear) begin
            queue_cmd(OP_CLEAR, 8'($urandom), 8'($urandom), 1'($urandom));
         end else if (pick < 87) begin
            queue_cmd(OP_SET_CURSOR, 8'($urandom), 8'($urandom_range(255, ROW_CHARS)), r);
            queue_cmd(OP_WRITE, 8'($urandom_range(255, 1)), 8'($urandom), 1'($urandom));
            queue_cmd(OP_WRITE, 8'h00, 8'($urandom), 1'($urandom));
         end else begin
            queue_cmd(opcode_type'($urandom_range(3)), 8'($urandom), 8'($urandom),
                      1'($urandom));
         end
      end
   endtask

   // Request driver: change inputs on the falling edge.
   always @(negedge clock) begin
      bit go;
      lcd_request_type q;
      if (!reset && (!start || req_taken)) begin
         go = request_backlog.size() != 0 && $urandom_range(99) >= idle_pct;
         if (go) begin
            q = request_backlog.pop_front();
            issued_count++;
            req_opcode <= q.op;
            req_char_value <= q.char_value;
            req_column <= q.column;
            req_row_select <= q.row_select;
         end
         start <= go;
      end
   end

   // Predict on each taken request, check each strobed character, watch for a hang.
   always @(posedge clock) begin
      lcd_request_type q;
      lcd_glyph_type want;
      req_taken = start && !busy;
      if (!reset) begin
         if (req_taken) begin
            q.op = opcode_type'(req_opcode);
            q.char_value = req_char_value;
            q.column = req_column;
            q.row_select = req_row_select;
            apply_request(q);
            taken_count++;
         end
         if (rsp_strobe) begin
            if (shown_glyphs.size() == 0) begin
               flag_mismatch($sformatf("character %h with no render pending", rsp_out_char));
            end else begin
               want = shown_glyphs.pop_front();
               if (rsp_out_row !== want.row)
                  flag_mismatch($sformatf("row %b, want %b", rsp_out_row, want.row));
               if (rsp_out_column !== want.column)
                  flag_mismatch($sformatf("column %0d, want %0d", rsp_out_column, want.column));
               if (rsp_out_char !== want.glyph)
                  flag_mismatch($sformatf("char %h, want %h (row %0d column %0d)",
                                          rsp_out_char, want.glyph, want.row, want.column));
               if (rsp_last !== want.last)
                  flag_mismatch($sformatf("last %b, want %b", rsp_last, want.last));
            end
         end
         if (req_taken || rsp_strobe) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("text_lcd_row_buffer_scroll regression: fail");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      csr_we = 1'b0;
      csr_wdata = MODE_NONE;
      req_opcode = OP_WRITE;
      req_char_value = 8'h00;
      req_column = 8'h00;
      req_row_select = 1'b0;
      wipe_text();
      view_offset = 0;
      view_mode = MODE_NONE;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_scroll_mode(MODE_NONE);
      // render of an empty store
      queue_cmd(OP_WRITE, 8'h00, 8'h00, 1'b0);
      queue_cmd(OP_WRITE, 8'h41, 8'hFF, 1'b1);
      queue_cmd(OP_WRITE, 8'h42, 8'h00, 1'b0);
      queue_cmd(OP_WRITE, 8'h00, 8'h00, 1'b0);
      queue_cmd(OP_SET_CURSOR, 8'h00, 8'd0, 1'b1);
      queue_cmd(OP_WRITE, 8'hFF, 8'h00, 1'b0);
      queue_cmd(OP_WRITE, 8'h01, 8'h00, 1'b0);
      queue_cmd(OP_WRITE, 8'h00, 8'h00, 1'b0);
      // last two cells of a row, then writes past its end
      queue_cmd(OP_SET_CURSOR, 8'hFF, 8'd38, 1'b0);
      queue_cmd(OP_WRITE, 8'h78, 8'h00, 1'b0);
      queue_cmd(OP_WRITE, 8'h79, 8'h00, 1'b0);
      queue_cmd(OP_WRITE, 8'h7A, 8'h00, 1'b0);
      queue_cmd(OP_WRITE, 8'h00, 8'h00, 1'b0);
      queue_cmd(OP_SET_CURSOR, 8'h00, 8'd255, 1'b1);
      queue_cmd(OP_WRITE, 8'h80, 8'h00, 1'b0);
      queue_cmd(OP_HOME, 8'hFF, 8'hFF, 1'b1);
      queue_cmd(OP_WRITE, 8'h48, 8'h00, 1'b0);
      queue_cmd(OP_WRITE, 8'h00, 8'h00, 1'b0);
      queue_cmd(OP_CLEAR, 8'hFF, 8'hFF, 1'b1);
      queue_cmd(OP_WRITE, 8'h00, 8'h00, 1'b0);
      wait_idle();

      // no clear here so the offset wraps in both directions
      set_scroll_mode(MODE_LEFT);
      add_random_traffic(130, 1'b0);
      set_scroll_mode(MODE_RIGHT);
      idle_pct = 0;
      add_random_traffic(130, 1'b0);
      wait_idle();
      idle_pct = 31;
      // a negative offset carried over into left scrolling
      set_scroll_mode(MODE_LEFT);
      add_random_traffic(80, 1'b1);
      set_scroll_mode(MODE_UNDEFINED);
      add_random_traffic(50, 1'b1);
      set_scroll_mode(MODE_NONE);
      add_random_traffic(30, 1'b1);
      wait_idle();
      add_random_traffic(30, 1'b1);
      wait_idle();

      if (mismatch_count == 0) begin
         $display("text_lcd_row_buffer_scroll regression: pass");
      end else begin
         $display("text_lcd_row_buffer_scroll regression: fail");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+src
src/lcdrb_pkg.sv
src/lcdrb_front.sv
src/lcdrb_cmdq.sv
src/lcdrb_back.sv
src/text_lcd_row_buffer_scroll.sv
src/lcdrb_checker.sv
test/text_lcd_row_buffer_scroll_test.sv
